>>> src/bba_pkg.sv
`default_nettype none

package bba_pkg;

  // bitmap word held in one memory row, block order msb first
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned LIMIT_W = POS_W + 1;

  // field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned BLOCK_W = 12;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned BASE_W  = 14;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

  // first block of a word sits in the top bit
  localparam logic [WORD_W-1:0] FIRST_BIT    = {1'b1, {(WORD_W-1){1'b0}}};
  // superblock and bitmap blocks used after format
  localparam logic [WORD_W-1:0] FORMAT_WORD0 = {2'b11, {(WORD_W-2){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_MARK   = 3'd2,
    OP_TEST   = 3'd3,
    OP_FORMAT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // outcome of a first-free search over one word
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } find_res_t;

endpackage

`default_nettype wire

>>> src/bba_ram.sv
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/bba_find_free.sv
`default_nettype none

module bba_find_free
  import bba_pkg::*;
(
  input  wire logic [WORD_W-1:0]  word_i,
  input  wire logic [LIMIT_W-1:0] limit_i,
  output find_res_t               res_o
);

  // lowest block in the word that is free and below the limit
  always_comb begin
    res_o = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (!word_i[WORD_W-1-j] && (LIMIT_W'(j) < limit_i)) begin
        res_o.found = 1'b1;
        res_o.pos   = POS_W'(j);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/block_bitmap_allocator.sv
// free-block bitmap allocator, 32 blocks per memory row
// allocate: one row checked per cycle by the scan pipeline
// free, mark, test: row read, modify-write (no write for test), result; out of range or unknown: straight to the result
// format: clearing one row per cycle, then the result
// reset: async, active low; a clearing pass then runs with
// the input stalled, leaving blocks 0 and 1 used and the count at 4096
`default_nettype none

module block_bitmap_allocator
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [OP_W-1:0]    operation_i,
  input  wire logic [BLOCK_W-1:0] block_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              status_o,
  output logic [BLOCK_W-1:0]      block_out_o,
  output logic                    used_bit_o
);

  localparam int unsigned WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [16:0] MAX_L = 17'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MODIFY,
    S_SCAN,
    S_DONE
  } state_e;

  state_e               state_q;
  op_e                  op_q;
  logic [BLOCK_W-1:0]   blk_q;
  logic [COUNT_W-1:0]   block_count_q;
  logic [AW-1:0]        clr_idx_q;
  logic                 clr_fmt_q;
  logic [BASE_W-1:0]    scan_base_q;
  logic [BASE_W-1:0]    chk_base_q;
  logic                 chk_vld_q;
  status_e              res_status_q;
  logic [BLOCK_W-1:0]   res_block_q;
  logic                 res_used_q;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [BLOCK_W-1:0]   out_block_q;
  logic                 out_used_q;

  logic [COUNT_W-1:0]   cnt_eff;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;
  logic [WORD_W-1:0]    blk_mask;
  logic                 blk_used;
  logic [BASE_W-1:0]    rem;
  logic                 last_word;
  logic [LIMIT_W-1:0]   limit;
  find_res_t            find;
  logic                 in_accept;
  logic                 out_free;

  // count in effect, saturated at the map size
  assign cnt_eff = ({4'b0, block_count_q} > MAX_L) ? COUNT_W'(MAX_L) : block_count_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // single-block access
  assign blk_mask = FIRST_BIT >> blk_q[POS_W-1:0];
  assign blk_used = |(ram_rdata & blk_mask);

  // blocks left from the word under check
  assign rem       = BASE_W'({1'b0, cnt_eff}) - chk_base_q;
  assign last_word = rem <= BASE_W'(WORD_W);
  assign limit     = last_word ? LIMIT_W'(rem) : LIMIT_W'(WORD_W);

  bba_find_free u_find (
    .word_i  (ram_rdata),
    .limit_i (limit),
    .res_o   (find)
  );

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(blk_q[BLOCK_W-1:POS_W]);
    ram_wdata = ram_rdata;
    ram_raddr = AW'(blk_q[BLOCK_W-1:POS_W]);
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_q;
        ram_wdata = (clr_idx_q == '0) ? FORMAT_WORD0 : '0;
      end
      S_MODIFY: begin
        ram_we    = (op_q == OP_FREE) || (op_q == OP_MARK);
        ram_wdata = (op_q == OP_FREE) ? (ram_rdata & ~blk_mask) : (ram_rdata | blk_mask);
      end
      S_SCAN: begin
        ram_raddr = AW'(scan_base_q[BASE_W-1:POS_W]);
        ram_we    = chk_vld_q && find.found;
        ram_waddr = AW'(chk_base_q[BASE_W-1:POS_W]);
        ram_wdata = ram_rdata | (FIRST_BIT >> find.pos);
      end
      default: begin
      end
    endcase
  end

  // sequencer, result staging and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      op_q          <= OP_ALLOC;
      blk_q         <= '0;
      block_count_q <= COUNT_RESET;
      clr_idx_q     <= '0;
      clr_fmt_q     <= 1'b0;
      scan_base_q   <= '0;
      chk_base_q    <= '0;
      chk_vld_q     <= 1'b0;
      res_status_q  <= ST_OK;
      res_block_q   <= '0;
      res_used_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      out_status_q  <= ST_OK;
      out_block_q   <= '0;
      out_used_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        block_count_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (clr_idx_q == AW'(WORDS - 1)) begin
            clr_idx_q    <= '0;
            res_status_q <= ST_OK;
            res_block_q  <= '0;
            res_used_q   <= 1'b0;
            state_q      <= clr_fmt_q ? S_DONE : S_IDLE;
          end else begin
            clr_idx_q <= clr_idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            op_q       <= op_e'(operation_i);
            blk_q      <= block_i;
            res_used_q <= 1'b0;
            case (operation_i)
              OP_ALLOC: begin
                res_block_q <= '0;
                if (cnt_eff == '0) begin
                  res_status_q <= ST_FULL;
                  state_q      <= S_DONE;
                end else begin
                  res_status_q <= ST_OK;
                  scan_base_q  <= '0;
                  chk_vld_q    <= 1'b0;
                  state_q      <= S_SCAN;
                end
              end
              OP_FREE, OP_MARK, OP_TEST: begin
                res_block_q <= block_i;
                if ({1'b0, block_i} >= cnt_eff) begin
                  res_status_q <= ST_RANGE;
                  state_q      <= S_DONE;
                end else begin
                  res_status_q <= ST_OK;
                  state_q      <= S_READ;
                end
              end
              OP_FORMAT: begin
                res_status_q <= ST_OK;
                res_block_q  <= '0;
                clr_idx_q    <= '0;
                clr_fmt_q    <= 1'b1;
                state_q      <= S_CLEAR;
              end
              default: begin
                res_status_q <= ST_OK;
                res_block_q  <= '0;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          state_q <= S_MODIFY;
        end
        S_MODIFY: begin
          res_used_q <= blk_used;
          state_q    <= S_DONE;
        end
        S_SCAN: begin
          scan_base_q <= scan_base_q + BASE_W'(WORD_W);
          chk_base_q  <= scan_base_q;
          if (chk_vld_q && find.found) begin
            res_block_q <= BLOCK_W'(chk_base_q + BASE_W'(find.pos));
            chk_vld_q   <= 1'b0;
            state_q     <= S_DONE;
          end else if (chk_vld_q && last_word) begin
            res_status_q <= ST_FULL;
            chk_vld_q    <= 1'b0;
            state_q      <= S_DONE;
          end else begin
            chk_vld_q <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_block_q  <= res_block_q;
            out_used_q   <= res_used_q;
            clr_fmt_q    <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign block_out_o = out_block_q;
  assign used_bit_o  = out_used_q;

  // an accepted word always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != S_IDLE)
    else $error("accepted word did not start work");

  // the map is only written while an operation or clearing pass runs
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !ram_we)
    else $error("map written outside an operation");

  // a full report carries no block
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (block_out_o == '0 && !used_bit_o))
    else $error("full report with block data");

  // the scan writes at most once per allocation
  a_scan_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && ram_we) |=> state_q == S_DONE)
    else $error("scan continued after an allocation");

endmodule

`default_nettype wire
